// ===== design/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, status codes and the record passed from the front end to the back
// end of the unit.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned DivPipeDepth = 2;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT   = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  // Operation class decided in the front end
  typedef enum logic [2:0] {
    CL_SIMPLE = 3'd0,
    CL_MUL    = 3'd1,
    CL_DIV    = 3'd2,
    CL_DIVZ   = 3'd3,
    CL_NONE   = 3'd4
  } class_e;

  typedef struct packed {
    logic [3:0]              op;
    class_e                  cls;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic                    lt;
    logic                    eq;
    logic                    gt;
  } item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    lt;
    logic                    eq;
    logic                    gt;
    logic [1:0]              status;
  } res_t;

endpackage

// ===== design/fixed_point_alu_q24_8.sv =====
// Items pass through the front register, the queue and the divider stages.
// Throughput: one item per cycle when not stalled; divider pipelined one bit per stage.
// The back pipeline stalls as a whole while a result waits on m_axis_tready.
// Reset clears all valid flags; no stored values need clearing.
// ----------------------------------------------------------------------------
// Fixed-point ALU, Q24.8
// Signed fixed-point arithmetic with comparison flags and status.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // op[3:0], operand_a[35:4], operand_b[67:36]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_value, a_less, a_equal, a_greater, status
);

  logic  f_valid, f_ready, q_valid, q_ready;
  item_t f_item, q_item;
  res_t  res;

  fpa_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tdata[3:0]),
    .a_i         (s_axis_tdata[35:4]),
    .b_i         (s_axis_tdata[67:36]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  fpa_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_item_i   (f_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_item_o  (q_item)
  );

  fpa_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {3'b000, res.status, res.gt, res.eq, res.lt, res.value};

endmodule

// ===== design/fpa_front.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Registers accepted items, compares the operands and classifies the opcode.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        op_i,
  input  logic [DataW-1:0]  a_i,
  input  logic [DataW-1:0]  b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output item_t             out_item_o
);

  logic  valid_q;
  item_t item_q, item_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    item_d.op = op_i;
    item_d.a  = a_i;
    item_d.b  = b_i;
    item_d.lt = $signed(a_i) < $signed(b_i);
    item_d.eq = a_i == b_i;
    item_d.gt = $signed(a_i) > $signed(b_i);
    unique case (op_i)
      OP_ADD, OP_SUB, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_FROM_INT, OP_TO_INT:
        item_d.cls = CL_SIMPLE;
      OP_MUL: item_d.cls = CL_MUL;
      OP_DIV: item_d.cls = (b_i == '0) ? CL_DIVZ : CL_DIV;
      default: item_d.cls = CL_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== design/fpa_queue.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU item queue
// Small FIFO between front and back end.
// ----------------------------------------------------------------------------
module fpa_queue import fpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign in_ready_o  = cnt_q != (PtrW+1)'(QueueDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

endmodule

// ===== design/fpa_divider.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU divider
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_divider import fpa_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [DataW-1:0]    a_i,
  input  logic [DataW-1:0]    b_i,
  output logic [DataW+FracBits-1:0] quot_o,
  output logic                neg_o
);

  localparam int unsigned NW = DataW + FracBits;

  logic [NW-1:0]   num_q [NW+1];
  logic [NW-1:0]   quo_q [NW+1];
  logic [DataW:0]  rem_q [NW+1];
  logic [DataW-1:0] den_q [NW+1];
  logic            neg_q [NW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= {($signed(a_i) < 0) ? -a_i : a_i, {FracBits{1'b0}}};
      den_q[0] <= ($signed(b_i) < 0) ? -b_i : b_i;
      neg_q[0] <= a_i[DataW-1] ^ b_i[DataW-1];
      rem_q[0] <= '0;
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DataW:0] trial;
    logic [DataW:0] diff;
    assign trial = {rem_q[s][DataW-1:0], num_q[s][NW-1]};
    assign diff  = trial - {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= diff[DataW] ? trial : diff;
        quo_q[s+1] <= {quo_q[s][NW-2:0], !diff[DataW]};
        num_q[s+1] <= num_q[s] << 1;
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign quot_o = quo_q[NW];
  assign neg_o  = neg_q[NW];

endmodule

// ===== design/fpa_back.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Lock-step pipeline: multiplier, divider and simple ops; the result is formed combinationally from the tail stage.
// ----------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_res_o
);

  localparam int unsigned NW = DataW + FracBits;
  localparam int unsigned Lat = NW + 1;

  logic           en;
  logic [Lat-1:0] vld_q;
  item_t          it_q [Lat];
  logic signed [2*DataW-1:0] prod_q [Lat];
  logic [NW-1:0]  quot;
  logic           neg;
  res_t           res;

  // whole pipeline advances together; stalls only when the tail is held
  assign en          = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Lat-1];
  assign out_res_o   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it_q[0]   <= in_item_i;
      prod_q[0] <= (2*DataW)'(in_item_i.a) * (2*DataW)'(in_item_i.b);
      for (int i = 1; i < Lat; i++) begin
        it_q[i]   <= it_q[i-1];
        prod_q[i] <= prod_q[i-1];
      end
    end
  end

  fpa_divider #(.FracBits(FracBits)) u_div (
    .clk_i,
    .en_i   (en),
    .a_i    (in_item_i.a),
    .b_i    (in_item_i.b),
    .quot_o (quot),
    .neg_o  (neg)
  );

  item_t                   t;
  logic signed [DataW+1:0] s;
  logic signed [2*DataW-1:0] w;
  logic signed [NW:0]      q;

  always_comb begin
    t = it_q[Lat-1];
    s = '0;
    w = '0;
    q = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    res.lt = t.lt;
    res.eq = t.eq;
    res.gt = t.gt;
    res.status = ST_OK;
    res.value = '0;
    unique case (t.cls)
      CL_MUL: begin
        w = prod_q[Lat-1] >>> FracBits;
        res.value = w[DataW-1:0];
        if (w != (2*DataW)'(res.value)) res.status = ST_OVERFLOW;
      end
      CL_DIV: begin
        res.value = q[DataW-1:0];
        if (q != (NW+1)'(res.value)) res.status = ST_OVERFLOW;
      end
      CL_DIVZ: res.status = ST_DIV_ZERO;
      CL_SIMPLE: begin
        case (t.op)
          OP_ADD: s = (DataW+2)'(t.a) + (DataW+2)'(t.b);
          OP_SUB: s = (DataW+2)'(t.a) - (DataW+2)'(t.b);
          OP_MIN: s = (DataW+2)'(t.lt ? t.a : t.b);
          OP_MAX: s = (DataW+2)'(t.gt ? t.a : t.b);
          OP_INC: s = (DataW+2)'(t.a) + (DataW+2)'(1);
          OP_DEC: s = (DataW+2)'(t.a) - (DataW+2)'(1);
          OP_TO_INT: s = (DataW+2)'(t.a >>> FracBits);
          default: s = '0;
        endcase
        if (t.op == OP_FROM_INT) begin
          w = (2*DataW)'(t.a) <<< FracBits;
          res.value = w[DataW-1:0];
          if (w != (2*DataW)'(res.value)) res.status = ST_OVERFLOW;
        end else begin
          res.value = s[DataW-1:0];
          if (s != (DataW+2)'(res.value)) res.status = ST_OVERFLOW;
        end
      end
      default: ;
    endcase
  end

endmodule
